### rtl/core/pbrm_pkg.sv
// Shared types and constants of the port bitmap range marker.
`timescale 1ns / 1ps
package pbrm_pkg;

	localparam int PORT_W    = 16;
	localparam int ACT_W     = 3;
	localparam int CNT_W     = 17;
	localparam int WORD_BITS = 8;
	localparam int BIT_W     = 3;

	// Action codes of an input transaction
	localparam logic [ACT_W-1:0] ACT_SET         = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR       = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TEST        = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SET_RANGE   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR_RANGE = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEAR_ALL   = 3'd5;

	// Memory operation kinds issued by the sequencer
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_CLR,
		OP_TEST,
		OP_ZERO
	} op_kind_t;

	typedef struct packed {
		logic              vld;
		op_kind_t          kind;
		logic [PORT_W-1:0] port;
		logic              last;
		logic [CNT_W-1:0]  touched;
	} op_t;

	typedef struct packed {
		logic             vld;
		logic             is_set;
		logic [CNT_W-1:0] touched;
	} res_t;

endpackage

### rtl/core/pbrm_req_if.sv
// Request channel interface: action, port bounds and step.
`timescale 1ns / 1ps
interface pbrm_req_if;
	import pbrm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic [PORT_W-1:0]        port;
	logic [PORT_W-1:0]        end_port;
	logic signed [PORT_W-1:0] step;

	modport source (output valid, action, port, end_port, step, input ready);
	modport sink (input valid, action, port, end_port, step, output ready);

endinterface

### rtl/core/pbrm_rsp_if.sv
// Response channel interface: test bit and touched count.
`timescale 1ns / 1ps
interface pbrm_rsp_if;
	import pbrm_pkg::*;

	logic             valid;
	logic             ready;
	logic             is_set;
	logic [CNT_W-1:0] touched;

	modport source (output valid, is_set, touched, input ready);
	modport sink (input valid, is_set, touched, output ready);

endinterface

### rtl/core/pbrm_ram.sv
// Bitmap word memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pbrm_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                           clk,
	input  logic                           re,
	input  logic [AW-1:0]                  raddr,
	output logic [pbrm_pkg::WORD_BITS-1:0] rdata,
	input  logic                           we,
	input  logic [AW-1:0]                  waddr,
	input  logic [pbrm_pkg::WORD_BITS-1:0] wdata
);
	import pbrm_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;

	// Read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/pbrm_rmw.sv
// Modify stage: merges read data, forwards last write, writes back, reports result.
`timescale 1ns / 1ps
module pbrm_rmw #(
	parameter int NUM_PORTS = 65536,
	parameter int AW        = 13
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pbrm_pkg::op_t                  issue,
	input  logic [pbrm_pkg::WORD_BITS-1:0] rdata,
	output logic                           we,
	output logic [AW-1:0]                  waddr,
	output logic [pbrm_pkg::WORD_BITS-1:0] wdata,
	output pbrm_pkg::res_t                 res
);
	import pbrm_pkg::*;

	op_t                  op_s1;
	logic                 fwd_vld_q;
	logic [AW-1:0]        fwd_addr_q;
	logic [WORD_BITS-1:0] fwd_data_q;

	logic                 in_rng;
	logic [AW-1:0]        addr;
	logic [BIT_W-1:0]     bidx;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mask;
	logic                 test_bit;

	// Op waits here while its word comes out of the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1     <= '0;
			fwd_vld_q <= 1'b0;
		end else begin
			op_s1     <= issue;
			fwd_vld_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= waddr;
		fwd_data_q <= wdata;
	end

	// Word select, with bypass of the write made in the previous cycle
	always_comb begin
		in_rng   = {1'b0, op_s1.port} < CNT_W'(NUM_PORTS);
		addr     = AW'(op_s1.port >> BIT_W);
		bidx     = op_s1.port[BIT_W-1:0];
		word     = (fwd_vld_q && fwd_addr_q == addr) ? fwd_data_q : rdata;
		mask     = WORD_BITS'(1) << bidx;
		test_bit = in_rng & word[bidx];
	end

	// Modify and write back
	always_comb begin
		we         = 1'b0;
		waddr      = addr;
		wdata      = word;
		res.vld    = op_s1.vld && op_s1.last;
		res.is_set = 1'b0;
		res.touched = op_s1.touched;
		unique case (op_s1.kind)
			OP_SET: begin
				we    = op_s1.vld && in_rng;
				wdata = word | mask;
			end
			OP_CLR: begin
				we    = op_s1.vld && in_rng;
				wdata = word & ~mask;
			end
			OP_ZERO: begin
				we    = op_s1.vld;
				wdata = '0;
			end
			OP_TEST: begin
				res.is_set = test_bit;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/pbrm_ctrl.sv
// Sequencer: takes requests, walks ranges and sweeps the map one word per cycle.
`timescale 1ns / 1ps
module pbrm_ctrl #(
	parameter int MAP_WORDS = 8192,
	parameter int AW        = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	pbrm_req_if.sink      req,
	input  logic          slot_free,
	input  logic          res_vld,
	output pbrm_pkg::op_t issue
);
	import pbrm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_CLEAR
	} state_t;

	state_t            state_q;
	logic              pend_q;
	logic [PORT_W-1:0] p_q;
	logic [PORT_W-1:0] rem_q;
	logic [PORT_W-1:0] mag_q;
	logic              up_q;
	logic              set_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [AW-1:0]     clr_addr_q;
	logic              clr_item_q;

	logic              accept;
	logic              clr_end;
	logic              walk_end;
	logic              is_range;
	logic              up;
	logic [PORT_W-1:0] mag;
	logic [PORT_W-1:0] step_u;

	assign req.ready = (state_q == ST_IDLE) && !pend_q && slot_free;
	assign accept    = req.valid && req.ready;
	assign clr_end   = clr_addr_q == AW'(MAP_WORDS - 1);
	assign walk_end  = rem_q < mag_q;
	assign is_range  = (req.action == ACT_SET_RANGE) || (req.action == ACT_CLEAR_RANGE);
	assign up        = req.port <= req.end_port;
	assign step_u    = req.step;

	// Step magnitude: zero counts as one, negative is negated
	always_comb begin
		if (step_u == '0) begin
			mag = PORT_W'(1);
		end else if (step_u[PORT_W-1]) begin
			mag = ~step_u + PORT_W'(1);
		end else begin
			mag = step_u;
		end
	end

	// Memory op for this cycle
	always_comb begin
		issue = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_range && req.action != ACT_CLEAR_ALL) begin
					issue.vld  = 1'b1;
					issue.port = req.port;
					issue.last = 1'b1;
					unique case (req.action)
						ACT_SET: begin
							issue.kind    = OP_SET;
							issue.touched = CNT_W'(1);
						end
						ACT_CLEAR: begin
							issue.kind    = OP_CLR;
							issue.touched = CNT_W'(1);
						end
						ACT_TEST: begin
							issue.kind = OP_TEST;
						end
						default: begin
							issue.kind = OP_NONE;
						end
					endcase
				end
			end
			ST_WALK: begin
				issue.vld     = 1'b1;
				issue.kind    = set_q ? OP_SET : OP_CLR;
				issue.port    = p_q;
				issue.last    = walk_end;
				issue.touched = cnt_q + CNT_W'(1);
			end
			ST_CLEAR: begin
				issue.vld  = 1'b1;
				issue.kind = OP_ZERO;
				issue.port = PORT_W'({clr_addr_q, {BIT_W{1'b0}}});
				issue.last = clr_item_q && clr_end;
			end
			default: begin
			end
		endcase
	end

	// State, walk registers and sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			pend_q     <= 1'b0;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= 1'b1;
			end else if (res_vld) begin
				pend_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && is_range) begin
						state_q <= ST_WALK;
					end else if (accept && req.action == ACT_CLEAR_ALL) begin
						state_q    <= ST_CLEAR;
						clr_addr_q <= '0;
						clr_item_q <= 1'b1;
					end
				end
				ST_WALK: begin
					if (walk_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					if (clr_end) begin
						state_q <= ST_IDLE;
					end else begin
						clr_addr_q <= clr_addr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			p_q   <= req.port;
			rem_q <= up ? (req.end_port - req.port) : (req.port - req.end_port);
			mag_q <= mag;
			up_q  <= up;
			set_q <= req.action == ACT_SET_RANGE;
			cnt_q <= '0;
		end else if (state_q == ST_WALK && !walk_end) begin
			p_q   <= up_q ? (p_q + mag_q) : (p_q - mag_q);
			rem_q <= rem_q - mag_q;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

endmodule

### rtl/core/port_bitmap_range_marker_unit.sv
// Top level of the port bitmap range marker.
//
//  channel | dir | fields                          | transfer
//  req     | in  | action, port, end_port, step    | valid & ready
//  rsp     | out | is_set, touched                 | valid & ready
//
// Set, clear, test and unknown actions: one read of the bitmap memory in the accept cycle;
//   set and clear write the modified word back in the following cycle.
// Range actions: one memory access per visited port.
// Clear all: one word zeroed per cycle.
// After reset a sweep zeroes all MAP_WORDS words (8192 by default); req.ready stays low.
// A two-entry response queue lets a new request in while a result waits for rsp.ready.
`timescale 1ns / 1ps
module port_bitmap_range_marker_unit #(
	parameter int NUM_PORTS = 65536
) (
	input logic        clk,
	input logic        arst_n,
	pbrm_req_if.sink   req,
	pbrm_rsp_if.source rsp
);
	import pbrm_pkg::*;

	localparam int MAP_WORDS = (NUM_PORTS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	op_t                  issue;
	res_t                 res;
	logic [WORD_BITS-1:0] rdata;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;

	res_t                 ent_q [2];
	logic [1:0]           cnt_q;
	logic                 wp_q;
	logic                 rp_q;
	logic                 pop;

	pbrm_ctrl #(
		.MAP_WORDS (MAP_WORDS),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.slot_free (cnt_q != 2'd2),
		.res_vld   (res.vld),
		.issue     (issue)
	);

	pbrm_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.re    (issue.vld),
		.raddr (AW'(issue.port >> BIT_W)),
		.rdata (rdata),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata)
	);

	pbrm_rmw #(
		.NUM_PORTS (NUM_PORTS),
		.AW        (AW)
	) u_rmw (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.rdata  (rdata),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.res    (res)
	);

	// Response queue pointers and fill count
	assign pop = rsp.valid && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (res.vld) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (res.vld && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !res.vld) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			ent_q[wp_q] <= res;
		end
	end

	assign rsp.valid   = cnt_q != 2'd0;
	assign rsp.is_set  = ent_q[rp_q].is_set;
	assign rsp.touched = ent_q[rp_q].touched;

endmodule

### rtl/core/pbrm_chk.sv
// Port-level checker for the port bitmap range marker, bound to the top level.
`timescale 1ns / 1ps
module pbrm_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_is_set,
	input logic [pbrm_pkg::CNT_W-1:0]   rsp_touched
);
	import pbrm_pkg::*;

	// Stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_set) && $stable(rsp_touched))
		else $error("response changed while stalled");

	// One transaction in flight: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// A result with is_set high reports no touched ports, and no count exceeds the port space
	a_rsp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_is_set && rsp_touched != '0) && rsp_touched <= CNT_W'(65536))
		else $error("response fields inconsistent");

	// Clearing sweep after reset holds requests off
	a_reset_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !req_ready)
		else $error("request accepted during reset sweep");

endmodule

bind port_bitmap_range_marker_unit pbrm_chk u_pbrm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_is_set  (rsp.is_set),
	.rsp_touched (rsp.touched)
);
